[src/kbt_pkg.sv]
// ----------------------------------------------------------------------------
// kbt_pkg
// shared types and constants for the box corner kalman tracker
// ----------------------------------------------------------------------------
package kbt_pkg;

  // item modes
  localparam logic [1:0] MODE_START = 2'd0;
  localparam logic [1:0] MODE_MEAS  = 2'd1;
  localparam logic [1:0] MODE_CHECK = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_PROC_NOISE = 2'd0;
  localparam logic [1:0] REG_MEAS_NOISE = 2'd1;
  localparam logic [1:0] REG_INIT_ERROR = 2'd2;
  localparam logic [1:0] REG_EXPIRY_MS  = 2'd3;

  // register reset values
  localparam logic [31:0] PROC_NOISE_RST = 32'd1678;
  localparam logic [31:0] MEAS_NOISE_RST = 32'd167772;
  localparam logic [31:0] INIT_ERROR_RST = 32'd16777216;
  localparam logic [31:0] EXPIRY_MS_RST  = 32'd3000;

  // fixed point constants
  localparam logic [24:0]        ONE_Q24     = 25'h1000000;
  localparam logic signed [15:0] ONE_Q14     = 16'sd16384;
  localparam logic signed [15:0] NEG_ONE_Q14 = -16'sd16384;

  // divider widths and step counts
  localparam int unsigned NUM_W     = 34;
  localparam int unsigned DEN_W     = 33;
  localparam int unsigned QUO_W     = 25;
  localparam int unsigned CNT_W     = 5;
  localparam logic [CNT_W-1:0] GAIN_BITS = 5'd25;
  localparam logic [CNT_W-1:0] CONF_BITS = 5'd15;

  // multiplier operand widths
  localparam int unsigned MUL_A_W = 34;
  localparam int unsigned MUL_B_W = 26;

  typedef struct packed {
    logic [1:0]         mode;
    logic [15:0]        track_id;
    logic signed [31:0] left_x;
    logic signed [31:0] left_y;
    logic signed [31:0] right_x;
    logic signed [31:0] right_y;
    logic [39:0]        now_ms;
  } kbt_in_t;

  typedef struct packed {
    logic [15:0]        id_out;
    logic signed [31:0] est_left_x;
    logic signed [31:0] est_left_y;
    logic signed [31:0] est_right_x;
    logic signed [31:0] est_right_y;
    logic [31:0]        error_var;
    logic signed [15:0] confidence;
    logic               expired;
  } kbt_out_t;

  typedef struct packed {
    logic             start;
    logic [CNT_W-1:0] nbits;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } kbt_div_req_t;

  typedef struct packed {
    logic             done;
    logic [QUO_W-1:0] quo;
  } kbt_div_rsp_t;

endpackage

[src/kbt_div.sv]
// ----------------------------------------------------------------------------
// kbt_div
// restoring divider, one quotient bit per cycle, numerator below twice divisor
// ----------------------------------------------------------------------------
module kbt_div
  import kbt_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  kbt_div_req_t req,
  output kbt_div_rsp_t rsp
);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NUM_W-1:0] rem_r;
  logic [DEN_W-1:0] den_r;
  logic [QUO_W-1:0] quo_r;

  logic             q_bit;
  logic [NUM_W-1:0] rem_sub;
  logic [NUM_W-1:0] rem_sel;
  logic [NUM_W-1:0] rem_nxt;
  logic [QUO_W-1:0] quo_nxt;

  always_comb begin
    q_bit   = (rem_r >= {1'b0, den_r});
    rem_sub = rem_r - {1'b0, den_r};
    rem_sel = q_bit ? rem_sub : rem_r;
    // partial remainder stays below the divisor, so the shift cannot overflow
    rem_nxt = {rem_sel[NUM_W-2:0], 1'b0};
    quo_nxt = {quo_r[QUO_W-2:0], q_bit};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.nbits;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= req.num;
      den_r <= req.den;
      quo_r <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
    end
  end

  assign rsp.done = done_r;
  assign rsp.quo  = quo_r;

endmodule

[src/kbt_mul.sv]
// ----------------------------------------------------------------------------
// kbt_mul
// shared signed multiplier with product register and q24 round half up
// ----------------------------------------------------------------------------
module kbt_mul
  import kbt_pkg::*;
(
  input  logic                      clk,
  input  logic                      load,
  input  logic signed [MUL_A_W-1:0] a_in,
  input  logic signed [MUL_B_W-1:0] b_in,
  output logic [31:0]               rnd_out
);

  localparam int unsigned PROD_W = MUL_A_W + MUL_B_W;

  logic signed [PROD_W-1:0] prod_r;
  logic signed [PROD_W-1:0] rnd_full;

  always_ff @(posedge clk) begin
    if (load) begin
      prod_r <= a_in * b_in;
    end
  end

  // add half an lsb, then the floor shift is a plain bit select
  assign rnd_full = prod_r + PROD_W'(64'd8388608);
  assign rnd_out  = rnd_full[55:24];

endmodule

[src/box_corner_kalman_tracker.sv]
// flow: start items and the unused mode go straight to the result, check items skip
//   the confidence divide on time reversal or long gaps and run it otherwise,
//   measure items run the 25-step gain divide (skipped when S is zero) plus five multiplies
// throughput: one item at a time; in_stall holds off new items until the result is registered
// reset: synchronous active low, track state and configuration registers return to defaults
// ----------------------------------------------------------------------------
// box_corner_kalman_tracker
// four-coordinate constant-position kalman tracker with shared error variance
// ----------------------------------------------------------------------------
module box_corner_kalman_tracker
  import kbt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  kbt_in_t     in_data,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output kbt_out_t    out_data,
  // configuration port
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_wdata
);

  // sequencer states
  typedef enum logic [7:0] {
    ST_IDLE = 8'b0000_0001,
    ST_PRED = 8'b0000_0010,
    ST_GAIN = 8'b0000_0100,
    ST_CHK  = 8'b0000_1000,
    ST_DIV  = 8'b0001_0000,
    ST_MUL  = 8'b0010_0000,
    ST_ACC  = 8'b0100_0000,
    ST_DONE = 8'b1000_0000
  } kbt_state_t;

  kbt_state_t state_r, state_nxt;

  // configuration registers
  logic [31:0] proc_noise_r;
  logic [31:0] meas_noise_r;
  logic [31:0] init_error_r;
  logic [31:0] expiry_ms_r;

  // track state
  logic signed [31:0] corner_r [4];
  logic [31:0]        err_var_r;
  logic [39:0]        last_seen_r;
  logic signed [15:0] conf_r;
  logic [15:0]        label_r;

  // captured transaction and working values
  logic [1:0]         mode_r;
  logic signed [31:0] meas_r [4];
  logic [39:0]        now_r;
  logic               expired_r;
  logic [31:0]        p_r;
  logic [QUO_W-1:0]   k_r;
  logic [2:0]         idx_r;

  // result register
  logic     out_valid_r;
  kbt_out_t out_data_r;

  logic in_acc;
  logic out_acc;

  // datapath helpers
  logic [32:0]          p_sum;
  logic [32:0]          s_sum;
  logic [31:0]          span;
  logic [39:0]          dt;
  logic                 time_back;
  logic                 dt_big;
  logic                 dt_over;
  logic signed [32:0]   diff;
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic                 mul_load;
  logic [31:0]          mul_rnd;

  kbt_div_req_t div_req;
  kbt_div_rsp_t div_rsp;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE);

  // predict: P + Q with saturation, then innovation variance S = P + R
  assign p_sum = {1'b0, err_var_r} + {1'b0, proc_noise_r};
  assign s_sum = {1'b0, p_r} + {1'b0, meas_noise_r};

  // expiry check: zero span counts as one millisecond
  assign span      = (expiry_ms_r == 32'd0) ? 32'd1 : expiry_ms_r;
  assign time_back = (now_r < last_seen_r);
  assign dt        = now_r - last_seen_r;
  assign dt_big    = (dt >= {7'd0, span, 1'b0});
  assign dt_over   = (dt > {8'd0, span});

  // shared multiplier: corner steps use K * (z - x), the variance uses P * (1 - K)
  assign diff  = {meas_r[idx_r[1:0]][31], meas_r[idx_r[1:0]]}
               - {corner_r[idx_r[1:0]][31], corner_r[idx_r[1:0]]};
  assign mul_a = idx_r[2] ? {2'b00, p_r} : {diff[32], diff};
  assign mul_b = idx_r[2] ? {1'b0, ONE_Q24 - k_r} : {1'b0, k_r};
  assign mul_load = (state_r == ST_MUL);

  // divider requests: gain from the predict path, confidence from the check path
  always_comb begin
    div_req = '0;
    if (state_r == ST_GAIN) begin
      div_req.start = (s_sum != 33'd0);
      div_req.nbits = GAIN_BITS;
      div_req.num   = {2'b00, p_r};
      div_req.den   = s_sum;
    end else if (state_r == ST_CHK) begin
      div_req.start = !time_back && !dt_big;
      div_req.nbits = CONF_BITS;
      div_req.num   = dt[NUM_W-1:0];
      div_req.den   = {1'b0, span};
    end
  end

  kbt_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  kbt_mul u_mul (
    .clk     (clk),
    .load    (mul_load),
    .a_in    (mul_a),
    .b_in    (mul_b),
    .rnd_out (mul_rnd)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_data.mode == MODE_MEAS) begin
            state_nxt = ST_PRED;
          end else if (in_data.mode == MODE_CHECK) begin
            state_nxt = ST_CHK;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_PRED: state_nxt = ST_GAIN;
      ST_GAIN: state_nxt = (s_sum == 33'd0) ? ST_MUL : ST_DIV;
      ST_CHK:  state_nxt = (time_back || dt_big) ? ST_DONE : ST_DIV;
      ST_DIV: begin
        if (div_rsp.done) begin
          state_nxt = (mode_r == MODE_MEAS) ? ST_MUL : ST_DONE;
        end
      end
      ST_MUL:  state_nxt = ST_ACC;
      ST_ACC:  state_nxt = idx_r[2] ? ST_DONE : ST_MUL;
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control, configuration and track state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      proc_noise_r <= PROC_NOISE_RST;
      meas_noise_r <= MEAS_NOISE_RST;
      init_error_r <= INIT_ERROR_RST;
      expiry_ms_r  <= EXPIRY_MS_RST;
      for (int i = 0; i < 4; i++) begin
        corner_r[i] <= '0;
      end
      err_var_r    <= '0;
      last_seen_r  <= '0;
      conf_r       <= ONE_Q14;
      label_r      <= '0;
      out_valid_r  <= 1'b0;
      idx_r        <= '0;
    end else begin
      state_r <= state_nxt;

      if (cfg_we) begin
        unique case (cfg_index)
          REG_PROC_NOISE: proc_noise_r <= cfg_wdata;
          REG_MEAS_NOISE: meas_noise_r <= cfg_wdata;
          REG_INIT_ERROR: init_error_r <= cfg_wdata;
          REG_EXPIRY_MS:  expiry_ms_r  <= cfg_wdata;
          default: ;
        endcase
      end

      // start loads the track straight from the transaction
      if (state_r == ST_IDLE && in_acc && in_data.mode == MODE_START) begin
        label_r     <= in_data.track_id;
        corner_r[0] <= in_data.left_x;
        corner_r[1] <= in_data.left_y;
        corner_r[2] <= in_data.right_x;
        corner_r[3] <= in_data.right_y;
        err_var_r   <= init_error_r;
        last_seen_r <= in_data.now_ms;
        conf_r      <= ONE_Q14;
      end

      if (state_r == ST_GAIN) begin
        idx_r <= '0;
      end

      // confidence saturates at minus one once the gap reaches twice the span
      if (state_r == ST_CHK && !time_back && dt_big) begin
        conf_r <= NEG_ONE_Q14;
      end

      if (state_r == ST_DIV && div_rsp.done) begin
        idx_r <= '0;
        if (mode_r != MODE_MEAS) begin
          conf_r <= ONE_Q14 - {1'b0, div_rsp.quo[14:0]};
        end
      end

      // apply one rounded product: a corner step or the corrected variance
      if (state_r == ST_ACC) begin
        if (idx_r[2]) begin
          err_var_r   <= mul_rnd;
          last_seen_r <= now_r;
        end else begin
          corner_r[idx_r[1:0]] <= corner_r[idx_r[1:0]] + mul_rnd;
          idx_r <= idx_r + 3'd1;
        end
      end

      // result register holds until the downstream side takes it
      if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r <= 1'b1;
      end else if (out_acc) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // transaction capture and working registers
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_acc) begin
      mode_r    <= in_data.mode;
      meas_r[0] <= in_data.left_x;
      meas_r[1] <= in_data.left_y;
      meas_r[2] <= in_data.right_x;
      meas_r[3] <= in_data.right_y;
      now_r     <= in_data.now_ms;
      expired_r <= 1'b0;
    end

    if (state_r == ST_PRED) begin
      p_r <= p_sum[32] ? 32'hFFFF_FFFF : p_sum[31:0];
    end

    // zero innovation variance gives zero gain
    if (state_r == ST_GAIN) begin
      k_r <= '0;
    end

    if (state_r == ST_CHK) begin
      expired_r <= time_back || dt_over;
    end

    if (state_r == ST_DIV && div_rsp.done && mode_r == MODE_MEAS) begin
      k_r <= div_rsp.quo;
    end

    if (state_r == ST_DONE && (!out_valid_r || !out_stall)) begin
      out_data_r.id_out      <= label_r;
      out_data_r.est_left_x  <= corner_r[0];
      out_data_r.est_left_y  <= corner_r[1];
      out_data_r.est_right_x <= corner_r[2];
      out_data_r.est_right_y <= corner_r[3];
      out_data_r.error_var   <= err_var_r;
      out_data_r.confidence  <= conf_r;
      out_data_r.expired     <= expired_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  // the divider only reports back while the sequencer waits for it
  assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> state_r == ST_DIV)
    else $error("divider done outside divide state");

  // the gain never exceeds one
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_MUL |-> k_r <= ONE_Q24)
    else $error("kalman gain above one");

  // confidence stays within minus one and one
  assert property (@(posedge clk) disable iff (!rst_n)
    conf_r >= NEG_ONE_Q14 && conf_r <= ONE_Q14)
    else $error("confidence out of range");

  // a measure transaction goes straight to the predict step
  assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_data.mode == MODE_MEAS |=> state_r == ST_PRED)
    else $error("measure transaction did not start predict");
`endif

endmodule
